[rtl/core/cma_pkg.sv]
// ----------------------------------------------------------------------------
// Centred moving average package
// Shared constants and types for the centred moving average block.
// ----------------------------------------------------------------------------
package cma_pkg;

  localparam int WS_W             = 7;
  localparam int MAX_HALF_DEF     = 63;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam logic [WS_W-1:0] WS_RESET = 7'd1;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CHECK,
    BK_DIV,
    BK_EMIT
  } back_state_e;

endpackage

[rtl/core/cma_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module cma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/cma_fifo.sv]
// ----------------------------------------------------------------------------
// Two-entry queue
// Decouples the front end from the back end of the averaging block.
// ----------------------------------------------------------------------------
module cma_fifo #(
  parameter int WIDTH = 23
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             valid_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       count_q, count_d;

  always_comb begin
    wptr_d  = wptr_q ^ push_i;
    rptr_d  = rptr_q ^ pop_i;
    count_d = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  assign full_o     = count_q[1];
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rptr_q];

endmodule

[rtl/core/cma_front.sv]
// ----------------------------------------------------------------------------
// Front end
// Holds the window size register, latches the half width at the start of
// each series and queues the samples for the back end.
// ----------------------------------------------------------------------------
module cma_front #(
  parameter int MAX_HALF    = cma_pkg::MAX_HALF_DEF,
  parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF,
  localparam int HALF_W     = $clog2(MAX_HALF + 1),
  localparam int ENT_W      = SAMPLE_BITS + 1 + HALF_W
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [cma_pkg::WS_W-1:0] cfg_win_len_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  input  logic                     last_i,
  output logic                     push_o,
  output logic [ENT_W-1:0]         push_data_o,
  input  logic                     full_i
);

  logic [cma_pkg::WS_W-1:0] win_len_q, win_len_d;
  logic                     in_series_q, in_series_d;
  logic [HALF_W-1:0]        half_q, half_d;
  logic [cma_pkg::WS_W-2:0] half_raw;
  logic [HALF_W-1:0]        half_cfg;
  logic [HALF_W-1:0]        half_use;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full_i;
  assign push_o      = in_valid_i && !full_i;

  assign half_raw = win_len_q[cma_pkg::WS_W-1:1];
  assign half_cfg = (32'(half_raw) > MAX_HALF) ? HALF_W'(MAX_HALF) : HALF_W'(half_raw);
  assign half_use = in_series_q ? half_q : half_cfg;

  assign push_data_o = {half_use, last_i, sample_i};

  always_comb begin
    win_len_d   = cfg_valid_i ? cfg_win_len_i : win_len_q;
    in_series_d = in_series_q;
    half_d      = half_q;
    if (push_o) begin
      in_series_d = !last_i;
      half_d      = half_use;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= cma_pkg::WS_RESET;
      in_series_q <= 1'b0;
      half_q      <= '0;
    end else begin
      win_len_q   <= win_len_d;
      in_series_q <= in_series_d;
      half_q      <= half_d;
    end
  end

endmodule

[rtl/core/cma_div.sv]
// ----------------------------------------------------------------------------
// Serial divider
// Unsigned restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cma_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W - 1);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[rtl/core/cma_back.sv]
// ----------------------------------------------------------------------------
// Back end
// Keeps the sample ring and the running window sum and produces the
// rounded centred means through the serial divider.
// ----------------------------------------------------------------------------
module cma_back #(
  parameter int MAX_HALF    = cma_pkg::MAX_HALF_DEF,
  parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF,
  localparam int HALF_W     = $clog2(MAX_HALF + 1),
  localparam int ENT_W      = SAMPLE_BITS + 1 + HALF_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [ENT_W-1:0]       data_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] average_o,
  output logic                   last_out_o
);

  localparam int CNT_W   = HALF_W + 1;
  localparam int RING_AW = CNT_W;
  localparam int SUM_W   = SAMPLE_BITS + CNT_W + 1;
  localparam int NUM_W   = SUM_W + 1;
  localparam int DEN_W   = CNT_W + 1;

  cma_pkg::back_state_e state_q, state_d;
  logic                 div_start;
  logic                 div_done;

  logic [RING_AW-1:0]     taken_q, taken_d;
  logic [RING_AW-1:0]     emitted_q, emitted_d;
  logic [HALF_W-1:0]      left_q, left_d;
  logic [HALF_W-1:0]      half_q, half_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic                   last_q, last_d;
  logic                   final_q, final_d;
  logic                   sub_q, sub_d;
  logic                   neg_q, neg_d;
  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0] out_avg_q, out_avg_d;
  logic                   out_last_q, out_last_d;

  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   in_last;
  logic [HALF_W-1:0]      in_half;
  logic [RING_AW-1:0]     pending;
  logic [CNT_W-1:0]       count;
  logic                   go;
  logic [SUM_W-1:0]       mag;
  logic [NUM_W-1:0]       num;
  logic [DEN_W-1:0]       den;
  logic [NUM_W-1:0]       quo;
  logic [SAMPLE_BITS-1:0] q_trunc;
  logic [SAMPLE_BITS-1:0] ring_rdata;
  logic                   ram_we;
  logic                   ram_re;
  logic                   emit_ok;

  assign in_sample = data_i[SAMPLE_BITS-1:0];
  assign in_last   = data_i[SAMPLE_BITS];
  assign in_half   = data_i[ENT_W-1:SAMPLE_BITS+1];

  assign pending = taken_q - emitted_q;
  assign count   = CNT_W'({1'b0, left_q}) + pending;
  assign go      = (pending != '0) && ((pending > RING_AW'(half_q)) || last_q);
  assign mag     = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign num     = {mag, 1'b0} + NUM_W'(count);
  assign den     = {count, 1'b0};
  assign q_trunc = quo[SAMPLE_BITS-1:0];
  assign emit_ok = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      cma_pkg::BK_IDLE:  if (valid_i) state_d = cma_pkg::BK_CHECK;
      cma_pkg::BK_CHECK: state_d = go ? cma_pkg::BK_DIV : cma_pkg::BK_IDLE;
      cma_pkg::BK_DIV:   if (div_done) state_d = cma_pkg::BK_EMIT;
      cma_pkg::BK_EMIT:  if (emit_ok) state_d = cma_pkg::BK_CHECK;
      default:           state_d = cma_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    div_start   = 1'b0;
    taken_d     = taken_q;
    emitted_d   = emitted_q;
    left_d      = left_q;
    half_d      = half_q;
    sum_d       = sum_q;
    last_d      = last_q;
    final_d     = final_q;
    sub_d       = sub_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_avg_d   = out_avg_q;
    out_last_d  = out_last_q;
    case (state_q)
      cma_pkg::BK_IDLE: begin
        if (valid_i) begin
          pop_o   = 1'b1;
          ram_we  = 1'b1;
          taken_d = taken_q + 1'b1;
          sum_d   = sum_q + SUM_W'(signed'(in_sample));
          half_d  = in_half;
          last_d  = in_last;
        end
      end
      cma_pkg::BK_CHECK: begin
        if (go) begin
          div_start = 1'b1;
          ram_re    = 1'b1;
          neg_d     = sum_q[SUM_W-1];
          final_d   = last_q && (pending == RING_AW'(1));
          sub_d     = (left_q == half_q);
        end else if (last_q) begin
          taken_d   = '0;
          emitted_d = '0;
          left_d    = '0;
          sum_d     = '0;
          last_d    = 1'b0;
        end
      end
      cma_pkg::BK_EMIT: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          out_avg_d   = neg_q ? SAMPLE_BITS'(-q_trunc) : q_trunc;
          out_last_d  = final_q;
          emitted_d   = emitted_q + 1'b1;
          if (sub_q) begin
            sum_d = sum_q - SUM_W'(signed'(ring_rdata));
          end else begin
            left_d = left_q + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cma_pkg::BK_IDLE;
      taken_q     <= '0;
      emitted_q   <= '0;
      left_q      <= '0;
      half_q      <= '0;
      sum_q       <= '0;
      last_q      <= 1'b0;
      final_q     <= 1'b0;
      sub_q       <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      taken_q     <= taken_d;
      emitted_q   <= emitted_d;
      left_q      <= left_d;
      half_q      <= half_d;
      sum_q       <= sum_d;
      last_q      <= last_d;
      final_q     <= final_d;
      sub_q       <= sub_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_avg_q <= out_avg_d;
  end

  cma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (2 ** RING_AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (taken_q),
    .wdata_i (in_sample),
    .re_i    (ram_re),
    .raddr_i (emitted_q - RING_AW'(left_q)),
    .rdata_o (ring_rdata)
  );

  cma_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign out_valid_o = out_valid_q;
  assign average_o   = out_avg_q;
  assign last_out_o  = out_last_q;

endmodule

[rtl/core/centered_moving_average.sv]
// ----------------------------------------------------------------------------
// Centred moving average
// Smooths a series of signed samples with a centred window that is cut
// short at both ends of the series, rounding to nearest.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Signals                            Transaction
//   cfg      in         cfg_valid_i/ready_o, win_len       window size write
//   in       in         in_valid_i/ready_o, sample, last   one sample
//   out      out        out_valid_o/ready_i, average, ...  one average
//
// Each average is computed by the one-bit-per-cycle serial divider in
// the back end, which takes no new sample while a division is running.
// Reset clears all control state; the sample ring is not cleared.
// The two-entry queue and the output register let input and output stall
// independently of each other.
//
module centered_moving_average #(
  parameter int MAX_HALF    = cma_pkg::MAX_HALF_DEF,
  parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [cma_pkg::WS_W-1:0] cfg_win_len_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  input  logic                     last_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [SAMPLE_BITS-1:0]   average_o,
  output logic                     last_out_o
);

  localparam int HALF_W = $clog2(MAX_HALF + 1);
  localparam int ENT_W  = SAMPLE_BITS + 1 + HALF_W;

  logic             push;
  logic [ENT_W-1:0] push_data;
  logic             full;
  logic             pop;
  logic [ENT_W-1:0] pop_data;
  logic             queue_valid;

  cma_front #(
    .MAX_HALF    (MAX_HALF),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_win_len_i (cfg_win_len_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .last_i        (last_i),
    .push_o        (push),
    .push_data_o   (push_data),
    .full_i        (full)
  );

  cma_fifo #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .valid_o     (queue_valid)
  );

  cma_back #(
    .MAX_HALF    (MAX_HALF),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (queue_valid),
    .data_i      (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .average_o   (average_o),
    .last_out_o  (last_out_o)
  );

endmodule

[tb/sv/centered_moving_average_tb.sv]
// ----------------------------------------------------------------------------
// Centred moving average testbench
// Drives series of signed samples through the block with random sender gaps
// and receiver stalls, predicts every average with a behavioural model of
// the cut-short centred window and checks each output transaction in order.
// ----------------------------------------------------------------------------
module centered_moving_average_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 64;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 12;

  typedef struct {
    logic [15:0] average;
    logic        last_out;
  } avg_item_t;

  typedef enum int {
    RX_FREE,
    RX_COIN,
    RX_BURSTY
  } rx_mode_e;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [cma_pkg::WS_W-1:0]  cfg_win_len_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [15:0]               sample_i;
  logic                      last_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [15:0]               average_o;
  logic                      last_out_o;

  // Behavioural state of the smoothing window.
  logic [15:0]               hist_ring [128];
  longint                    run_sum;
  logic [7:0]                n_taken;
  logic [6:0]                n_emitted;
  int                        n_left;
  int                        cur_half;
  bit                        series_open;
  logic [cma_pkg::WS_W-1:0]  win_size;

  avg_item_t                 avg_due_q [$];
  int                        bad_count;
  int                        idle_cycles;

  // Sender and receiver pacing.
  bit                        steady_send;
  int                        burst_left;
  int                        hold_request;
  int                        hold_left;
  int                        mode_left;
  int                        stall_left;
  rx_mode_e                  rx_mode;

  centered_moving_average u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_win_len_i (cfg_win_len_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .average_o     (average_o),
    .last_out_o    (last_out_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [15:0] round_mean(input longint total, input int cnt);
    longint mag;
    longint q;
    mag = (total < 0) ? -total : total;
    q = (2 * mag + cnt) / (2 * cnt);
    if (total < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic void clear_window();
    run_sum     = 0;
    n_taken     = '0;
    n_emitted   = '0;
    n_left      = 0;
    cur_half    = 0;
    series_open = 1'b0;
  endfunction

  function automatic void smooth_sample(input logic [15:0] s, input logic l);
    logic [6:0] pend;
    logic [6:0] idx;
    int         n;
    avg_item_t  item;
    n = 0;
    if (!series_open) begin
      cur_half = int'(win_size) >> 1;
      if (cur_half > cma_pkg::MAX_HALF_DEF) cur_half = cma_pkg::MAX_HALF_DEF;
      series_open = 1'b1;
    end
    hist_ring[n_taken[6:0]] = s;
    run_sum += longint'($signed(s));
    n_taken++;
    while (1'b1) begin
      pend = n_taken[6:0] - n_emitted;
      if (pend == 0) break;
      if (int'(pend) < cur_half + 1 && !l) break;
      if (n >= 64) break;
      item.average  = round_mean(run_sum, n_left + int'(pend));
      item.last_out = l && (pend == 7'd1);
      avg_due_q.push_back(item);
      n++;
      if (n_left >= cur_half) begin
        idx = n_emitted - 7'(n_left);
        run_sum -= longint'($signed(hist_ring[idx]));
      end else begin
        n_left++;
      end
      n_emitted++;
    end
    if (l) clear_window();
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic [15:0] s, input logic l);
    int gap;
    gap = 0;
    if (!steady_send) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 10);
      end
      burst_left--;
    end
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    last_i     <= l;
    do @(posedge clk_i); while (!in_ready_o);
    smooth_sample(s, l);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (avg_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [cma_pkg::WS_W-1:0] ws);
    @(negedge clk_i);
    cfg_valid_i   <= 1'b1;
    cfg_win_len_i <= ws;
    do @(posedge clk_i); while (!cfg_ready_o);
    win_size = ws;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_series(input int len);
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  task automatic test_reset_window();
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b1);
    settle();
  endtask

  task automatic test_single_sample();
    write_window(7'd0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b1);
    settle();
    write_window(7'd127);
    send_sample(16'h1234, 1'b1);
    settle();
  endtask

  task automatic test_rounding_ties();
    write_window(7'd2);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0000, 1'b1);
    settle();
  endtask

  task automatic test_full_window();
    // The widest window with a series long enough to flush the most averages.
    write_window(7'd127);
    send_series(64);
    settle();
  endtask

  task automatic test_window_change_mid_series();
    // The half width is latched at the start of a series.
    write_window(7'd5);
    for (int i = 0; i < 4; i++) send_sample(pick_sample(), 1'b0);
    settle();
    write_window(7'd9);
    for (int i = 0; i < 6; i++) send_sample(pick_sample(), i == 5);
    send_series(4);
    settle();
  endtask

  task automatic test_receiver_hold_off();
    write_window(7'd9);
    hold_request = HOLD_CYCLES;
    steady_send  = 1'b1;
    send_series(20);
    steady_send  = 1'b0;
    settle();
  endtask

  task automatic test_random_series();
    int taken;
    int len;
    logic [cma_pkg::WS_W-1:0] ws;
    taken = 0;
    while (taken < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) ws = $urandom_range(0, 127);
      else ws = $urandom_range(0, 12);
      write_window(ws);
      if ($urandom_range(0, 7) == 0) len = $urandom_range(13, 20);
      else len = $urandom_range(1, 12);
      send_series(len);
      taken += len;
      settle();
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (hold_request > 0) begin
      hold_left    = hold_request - 1;
      hold_request = 0;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 200);
      end
      mode_left--;
      case (rx_mode)
        RX_FREE: out_ready_i <= 1'b1;
        RX_COIN: out_ready_i <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ready_i <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 7);
            out_ready_i <= 1'b0;
          end else begin
            out_ready_i <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    avg_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (avg_due_q.size() == 0) begin
        $error("Unexpected average transaction: average %0d last_out %0b",
               $signed(average_o), last_out_o);
        bad_count++;
      end else begin
        want = avg_due_q.pop_front();
        if (average_o !== want.average) begin
          $error("average: expected %0d, actual %0d",
                 $signed(want.average), $signed(average_o));
          bad_count++;
        end
        if (last_out_o !== want.last_out) begin
          $error("last_out: expected %0b, actual %0b", want.last_out, last_out_o);
          bad_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_win_len_i = '0;
    in_valid_i    = 1'b0;
    sample_i      = '0;
    last_i        = 1'b0;
    out_ready_i   = 1'b0;
    bad_count     = 0;
    idle_cycles   = 0;
    steady_send   = 1'b0;
    burst_left    = 0;
    hold_request  = 0;
    hold_left     = 0;
    mode_left     = 0;
    stall_left    = 0;
    rx_mode       = RX_FREE;
    win_size      = cma_pkg::WS_RESET;
    clear_window();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_window();
    test_single_sample();
    test_rounding_ties();
    test_full_window();
    test_window_change_mid_series();
    test_receiver_hold_off();
    test_random_series();
    settle();

    if (bad_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
